>>> hdl/sme_pkg.sv
// Shared types and constants for the sorted multiset engine.
// No dependencies; used by sme_cell and sorted_multiset_engine.
`default_nettype none
package sme_pkg;

	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int MODE_W   = 2;
	localparam int KIND_W   = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD    = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_FINISH = 2'd2
	} mode_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ELEM     = 2'd0,
		KIND_MISSING  = 2'd1,
		KIND_EMPTY    = 2'd2,
		KIND_OVERFLOW = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     occupied;
		logic     left_le;
	} cell_ctl_t;

	typedef struct packed {
		logic le;
		logic lt;
		logic eq;
	} cell_sts_t;

	typedef enum logic {
		ST_IDLE,
		ST_FIN
	} sme_state_t;

endpackage
`default_nettype wire

>>> hdl/sme_cell.sv
// One slot of the sorted chain: holds a value, compares it with the item
// value and takes the item value or a neighbour's value. Uses sme_pkg.
`default_nettype none
module sme_cell (
	input  wire logic                              clk,
	input  wire sme_pkg::cell_ctl_t                ctl,
	input  wire logic signed [sme_pkg::DATA_W-1:0] din,
	input  wire logic signed [sme_pkg::DATA_W-1:0] left_val,
	input  wire logic signed [sme_pkg::DATA_W-1:0] right_val,
	output logic signed [sme_pkg::DATA_W-1:0]      val,
	output sme_pkg::cell_sts_t                     sts
);

	logic signed [sme_pkg::DATA_W-1:0] val_q;

	assign val    = val_q;
	assign sts.le = ctl.occupied && (val_q <= din);
	assign sts.lt = ctl.occupied && (val_q < din);
	assign sts.eq = ctl.occupied && (val_q == din);

	// the chain stays sorted, so le and lt are prefixes of the row
	always_ff @(posedge clk) begin
		case (ctl.op)
			sme_pkg::CELL_INSERT: begin
				if (!sts.le) begin
					val_q <= ctl.left_le ? din : left_val;
				end
			end
			sme_pkg::CELL_REMOVE: begin
				if (!sts.lt) begin
					val_q <= right_val;
				end
			end
			sme_pkg::CELL_SHIFT: val_q <= right_val;
			default: val_q <= val_q;
		endcase
	end

endmodule
`default_nettype wire

>>> hdl/sorted_multiset_engine.sv
// Top level of the sorted multiset engine: control, fill count, flags,
// output register and the row of sme_cell slots. Uses sme_pkg.
//
//  channel  | dir | tdata          | tuser     | tlast
//  s_axis   | in  | [31:0] value   | [1:0] mode | -
//  m_axis   | out | [31:0] element | [1:0] kind | last
//
// Add, remove and unused-mode items are taken while no dump runs; the row of
// cells compares and shifts all slots together for each taken item.
// A finish item starts a dump of the results in order: the dump shifts the row
// left by one slot per loaded result, and output stalls hold the dump.
// No item is accepted while a dump runs. Reset clears count, flags and
// control; slot contents stay undefined until written.
`default_nettype none
module sorted_multiset_engine #(
	parameter int CAPACITY = sme_pkg::CAPACITY
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_axis_tvalid,
	output logic                           s_axis_tready,
	input  wire logic [sme_pkg::DATA_W-1:0] s_axis_tdata,  // [31:0] value
	input  wire logic [sme_pkg::MODE_W-1:0] s_axis_tuser,  // [1:0] mode
	output logic                           m_axis_tvalid,
	input  wire logic                      m_axis_tready,
	output logic [sme_pkg::DATA_W-1:0]     m_axis_tdata,  // [31:0] element
	output logic [sme_pkg::KIND_W-1:0]     m_axis_tuser,  // [1:0] kind
	output logic                           m_axis_tlast
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	sme_pkg::sme_state_t state_q, state_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic                miss_q, miss_d;
	logic                ovf_q, ovf_d;
	sme_pkg::cell_op_t   op;

	logic                          m_valid_q, m_valid_d;
	logic                          out_load;
	sme_pkg::kind_t                kind_q, kind_d;
	logic [sme_pkg::DATA_W-1:0]    elem_q, elem_d;
	logic                          last_q, last_d;

	logic signed [sme_pkg::DATA_W-1:0] din;
	logic signed [sme_pkg::DATA_W-1:0] vals [CAPACITY];
	sme_pkg::cell_sts_t                sts  [CAPACITY];
	logic [CAPACITY-1:0]               eq_vec;
	logic                              found;
	logic                              in_acc;
	logic                              slot_free;
	sme_pkg::mode_t                    mode;

	assign din       = s_axis_tdata;
	assign mode      = sme_pkg::mode_t'(s_axis_tuser);
	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign slot_free = !m_valid_q || m_axis_tready;
	assign found     = |eq_vec;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		sme_pkg::cell_ctl_t                ctl;
		logic signed [sme_pkg::DATA_W-1:0] left_v, right_v;

		assign ctl.op       = op;
		assign ctl.occupied = CNT_W'(i) < cnt_q;
		assign eq_vec[i]    = sts[i].eq;

		if (i == 0) begin : g_first
			assign ctl.left_le = 1'b1;
			assign left_v      = din;
		end else begin : g_mid
			assign ctl.left_le = sts[i-1].le;
			assign left_v      = vals[i-1];
		end

		// the far end has no neighbour; what it takes there is never read
		if (i == CAPACITY - 1) begin : g_end
			assign right_v = vals[i];
		end else begin : g_inner
			assign right_v = vals[i+1];
		end

		sme_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.din       (din),
			.left_val  (left_v),
			.right_val (right_v),
			.val       (vals[i]),
			.sts       (sts[i])
		);
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		miss_d   = miss_q;
		ovf_d    = ovf_q;
		op       = sme_pkg::CELL_HOLD;
		out_load = 1'b0;
		kind_d   = sme_pkg::KIND_ELEM;
		elem_d   = '0;
		last_d   = 1'b1;
		s_axis_tready = (state_q == sme_pkg::ST_IDLE);

		case (state_q)
			sme_pkg::ST_IDLE: begin
				if (in_acc) begin
					case (mode)
						sme_pkg::MODE_ADD: begin
							if (cnt_q == CNT_W'(CAPACITY)) begin
								ovf_d = 1'b1;
							end else begin
								op    = sme_pkg::CELL_INSERT;
								cnt_d = cnt_q + 1'b1;
							end
						end
						sme_pkg::MODE_REMOVE: begin
							if (found) begin
								op    = sme_pkg::CELL_REMOVE;
								cnt_d = cnt_q - 1'b1;
							end else begin
								miss_d = 1'b1;
							end
						end
						sme_pkg::MODE_FINISH: state_d = sme_pkg::ST_FIN;
						default: ;
					endcase
				end
			end
			sme_pkg::ST_FIN: begin
				if (slot_free) begin
					out_load = 1'b1;
					if (miss_q) begin
						kind_d = sme_pkg::KIND_MISSING;
					end else if (ovf_q) begin
						kind_d = sme_pkg::KIND_OVERFLOW;
					end else if (cnt_q == '0) begin
						kind_d = sme_pkg::KIND_EMPTY;
					end else begin
						kind_d = sme_pkg::KIND_ELEM;
						elem_d = vals[0];
						op     = sme_pkg::CELL_SHIFT;
						cnt_d  = cnt_q - 1'b1;
						last_d = (cnt_q == CNT_W'(1));
					end
					if (last_d) begin
						state_d = sme_pkg::ST_IDLE;
						cnt_d   = '0;
						miss_d  = 1'b0;
						ovf_d   = 1'b0;
					end
				end
			end
			default: state_d = sme_pkg::ST_IDLE;
		endcase
	end

	assign m_valid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sme_pkg::ST_IDLE;
			cnt_q     <= '0;
			miss_q    <= 1'b0;
			ovf_q     <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			miss_q    <= miss_d;
			ovf_q     <= ovf_d;
			m_valid_q <= m_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q <= kind_d;
			elem_q <= elem_d;
			last_q <= last_d;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = elem_q;
	assign m_axis_tuser  = kind_q;
	assign m_axis_tlast  = last_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("fill count beyond capacity");

	a_status_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && kind_q != sme_pkg::KIND_ELEM |-> m_axis_tlast && elem_q == '0)
		else $error("status result without last or with nonzero element");

	a_dump_clears: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sme_pkg::ST_FIN && state_d == sme_pkg::ST_IDLE
		|=> cnt_q == '0 && !miss_q && !ovf_q && m_axis_tvalid && m_axis_tlast)
		else $error("finish did not clear state or give a last result");

	a_no_take_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sme_pkg::ST_FIN |-> !s_axis_tready)
		else $error("item taken during dump");

endmodule
`default_nettype wire

>>> tb/sorted_multiset_engine_tb.sv
// Self-checking bench for sorted_multiset_engine: streams add, remove and finish
// items, predicts every dump from a sorted queue and checks each result item.
// Depends on sme_pkg and the sorted_multiset_engine RTL.
module sorted_multiset_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sme_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int                LIMIT_CYCLES = 200000;
	localparam int                TAIL_CYCLES  = 8;
	localparam int                RANDOM_ITEMS = 250;
	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [DATA_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		kind_t             kind;
		logic [DATA_W-1:0] element;
		logic              last;
	} dump_t;

	logic                clk;
	logic                arst_n        = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [DATA_W-1:0]   s_axis_tdata  = '0;
	logic [MODE_W-1:0]   s_axis_tuser  = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [DATA_W-1:0]   m_axis_tdata;
	logic [KIND_W-1:0]   m_axis_tuser;
	logic                m_axis_tlast;

	sorted_multiset_engine DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	cmd_t                       pending_cmds[$];
	dump_t                      expected_dump[$];
	logic signed [DATA_W-1:0]   multiset[$];
	logic                       missing_seen  = 1'b0;
	logic                       overflow_seen = 1'b0;
	int unsigned                items_accepted = 0;
	int unsigned                mismatches = 0;
	int unsigned                cycles = 0;
	cmd_t                       next_cmd;
	dump_t                      want;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// idle phases rotate every 24 accepted items: none, sender, receiver, both
	function automatic int unsigned send_gap_pct();
		case ((items_accepted / 24) % 4)
			1: send_gap_pct = 58;
			3: send_gap_pct = 12;
			default: send_gap_pct = 0;
		endcase
	endfunction

	function automatic int unsigned recv_stall_pct();
		case ((items_accepted / 24) % 4)
			2: recv_stall_pct = 58;
			3: recv_stall_pct = 12;
			default: recv_stall_pct = 0;
		endcase
	endfunction

	// Update the predicted multiset and queue the dump a finish produces
	function automatic void apply_cmd(cmd_t c);
		logic signed [DATA_W-1:0] v;
		int pos;
		v = $signed(c.value);
		pos = 0;
		if (c.mode == MODE_ADD) begin
			if (multiset.size() >= CAPACITY) begin
				overflow_seen = 1'b1;
			end else begin
				// new value goes after any equal ones
				while (pos < multiset.size() && multiset[pos] <= v) pos++;
				multiset.insert(pos, v);
			end
		end else if (c.mode == MODE_REMOVE) begin
			while (pos < multiset.size() && multiset[pos] != v) pos++;
			if (pos >= multiset.size())
				missing_seen = 1'b1;
			else
				multiset.delete(pos);
		end else if (c.mode == MODE_FINISH) begin
			if (missing_seen)
				expected_dump.push_back('{KIND_MISSING, '0, 1'b1});
			else if (overflow_seen)
				expected_dump.push_back('{KIND_OVERFLOW, '0, 1'b1});
			else if (multiset.size() == 0)
				expected_dump.push_back('{KIND_EMPTY, '0, 1'b1});
			else
				foreach (multiset[i])
					expected_dump.push_back('{KIND_ELEM, multiset[i],
						logic'(i == multiset.size() - 1)});
			multiset.delete();
			missing_seen  = 1'b0;
			overflow_seen = 1'b0;
		end
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				apply_cmd('{s_axis_tuser, s_axis_tdata});
				items_accepted <= items_accepted + 1;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= send_gap_pct()) begin
					next_cmd = pending_cmds.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= next_cmd.value;
					s_axis_tuser  <= next_cmd.mode;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_dump.size() == 0) begin
					$error("result item with nothing expected: kind %0d element %0d",
						m_axis_tuser, $signed(m_axis_tdata));
					mismatches++;
				end else begin
					want = expected_dump.pop_front();
					if (m_axis_tuser !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
						mismatches++;
					end
					if (m_axis_tdata !== want.element) begin
						$error("element: expected %0d, got %0d",
							$signed(want.element), $signed(m_axis_tdata));
						mismatches++;
					end
					if (m_axis_tlast !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, m_axis_tlast);
						mismatches++;
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct());
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("sorted_multiset_engine: mismatch");
			$finish;
		end
	end

	task automatic push_cmd(logic [MODE_W-1:0] mode, logic signed [DATA_W-1:0] value);
		pending_cmds.push_back('{mode, value});
	endtask

	// mostly small values so duplicates and removable hits are common
	function automatic logic signed [DATA_W-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 50)
			pick_value = $signed($urandom_range(10)) - 5;
		else if (r < 65)
			case ($urandom_range(3))
				0: pick_value = VAL_MIN;
				1: pick_value = VAL_MAX;
				2: pick_value = 0;
				default: pick_value = -1;
			endcase
		else
			pick_value = $signed($urandom);
	endfunction

	initial begin
		logic signed [DATA_W-1:0] added[$];
		logic signed [DATA_W-1:0] v;
		int unsigned random_items;
		int unsigned seq_no;
		int unsigned n;
		int unsigned idx;
		int unsigned r;
		int unsigned big;

		random_items = 0;
		seq_no = 0;

		// directed: empty finish, extremes with duplicates, unused mode,
		// missing value, add then remove back to empty, finish with a junk value
		push_cmd(MODE_FINISH, 0);
		push_cmd(MODE_ADD, VAL_MAX);
		push_cmd(MODE_ADD, VAL_MIN);
		push_cmd(MODE_ADD, 0);
		push_cmd(MODE_ADD, -1);
		push_cmd(MODE_ADD, VAL_MAX);
		push_cmd(MODE_ADD, 1);
		push_cmd(MODE_UNUSED, -1);
		push_cmd(MODE_REMOVE, 0);
		push_cmd(MODE_REMOVE, VAL_MAX);
		push_cmd(MODE_FINISH, 0);
		push_cmd(MODE_REMOVE, 5);
		push_cmd(MODE_ADD, 7);
		push_cmd(MODE_FINISH, 0);
		push_cmd(MODE_ADD, 3);
		push_cmd(MODE_REMOVE, 3);
		push_cmd(MODE_FINISH, 0);
		push_cmd(MODE_UNUSED, VAL_MIN);
		push_cmd(MODE_FINISH, -1);

		while (random_items < RANDOM_ITEMS) begin
			added.delete();
			r = $urandom_range(99);
			// full store: exact fill, overflow, and overflow hidden by a miss
			if (seq_no < 2 || (r < 3 && random_items < 150)) begin
				big = (seq_no == 1) ? CAPACITY : CAPACITY + 1 + (seq_no > 1);
				for (int i = 0; i < big; i++)
					push_cmd(MODE_ADD, pick_value());
				if (seq_no > 1)
					push_cmd(MODE_REMOVE, $signed($urandom));
				push_cmd(MODE_FINISH, $signed($urandom));
				random_items += big + 1 + (seq_no > 1);
			end else begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++) begin
					r = $urandom_range(99);
					if (r < 25 && added.size() != 0) begin
						idx = $urandom_range(added.size() - 1);
						push_cmd(MODE_REMOVE, added[idx]);
						added.delete(idx);
					end else if (r < 33) begin
						push_cmd(MODE_REMOVE, $signed($urandom));
					end else if (r < 38) begin
						push_cmd(MODE_UNUSED, $signed($urandom));
					end else begin
						v = pick_value();
						push_cmd(MODE_ADD, v);
						added.push_back(v);
					end
				end
				random_items += n;
				if ($urandom_range(9) != 0) begin
					push_cmd(MODE_FINISH, $signed($urandom));
					random_items++;
				end
			end
			seq_no++;
		end
		push_cmd(MODE_FINISH, 0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || s_axis_tvalid || expected_dump.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_dump.size() == 0)
			$display("sorted_multiset_engine: match");
		else
			$display("sorted_multiset_engine: mismatch");
		$finish;
	end

endmodule

>>> filelist.f
hdl/sme_pkg.sv
hdl/sme_cell.sv
hdl/sorted_multiset_engine.sv
tb/sorted_multiset_engine_tb.sv
